>>> design/pnbm_pkg.sv
package pnbm_pkg;

   localparam int MAX_PIXELS_DEF    = 2048;
   localparam int MAX_NEIGHBORS_DEF = 8;
   localparam int COORD_BITS_DEF    = 24;

   localparam int FIELD_XY_W  = 24;
   localparam int QUERY_W     = 11;
   localparam int COUNT_W     = 4;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 4;

   localparam int CAND_MAX = 9;
   localparam int SLOT_W   = 4;
   localparam int NUM_W    = 16;
   localparam int DEN_W    = 14;

   localparam logic [SLOT_W-1:0] K1_HEX    = 4'd7;
   localparam logic [SLOT_W-1:0] K1_SQUARE = 4'd5;
   localparam logic [SLOT_W-1:0] K1_DIAG   = 4'd9;
   localparam logic [NUM_W-1:0]  NUM_NEAR  = 16'd49;
   localparam logic [DEN_W-1:0]  DEN_NEAR  = 14'd25;
   localparam logic [NUM_W-1:0]  NUM_DIAG  = 16'd39601;
   localparam logic [DEN_W-1:0]  DEN_DIAG  = 14'd10000;

   localparam logic [CSR_INDEX_W-1:0] CSR_GRID_TYPE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIAGONAL     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BORDER_WIDTH = 2'd2;

   localparam logic [1:0] GRID_SQUARE  = 2'd2;
   localparam logic [1:0] GRID_INVALID = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE, ST_CAPTURE, ST_BUILD, ST_XI_READ, ST_XI_LATCH, ST_SCAN, ST_PREP,
      ST_MUL, ST_KEEP, ST_NB_DONE, ST_BM_RD, ST_BM_WR, ST_GR_RD, ST_GR_LATCH,
      ST_GR_TEST, ST_GR_NL, ST_GR_NB
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_QUERY, OP_CAPTURE, OP_BUILD, OP_XI_READ, OP_XI_LATCH,
      OP_SCAN, OP_PREP, OP_MUL, OP_KEEP, OP_NB_DONE, OP_BM_RD, OP_BM_WR, OP_GR_RD,
      OP_GR_LATCH, OP_GR_TEST, OP_GR_NL, OP_GR_NB
   } op_type;

   typedef struct packed {
      logic rsp_free;
      logic skip_build;
      logic scan_done;
      logic p_last;
      logic i_last;
      logic width_one;
      logic iter_last;
      logic grow_stop;
   } status_type;

endpackage

>>> design/pnbm_req_if.sv
interface pnbm_req_if;
   import pnbm_pkg::*;
   logic                         valid;
   logic                         ready;
   logic                         mode;
   logic signed [FIELD_XY_W-1:0] pixel_x;
   logic signed [FIELD_XY_W-1:0] pixel_y;
   logic                         last;
   logic [QUERY_W-1:0]           query_index;

   modport source (output valid, mode, pixel_x, pixel_y, last, query_index, input ready);
   modport sink (input valid, mode, pixel_x, pixel_y, last, query_index, output ready);
endinterface

>>> design/pnbm_rsp_if.sv
interface pnbm_rsp_if;
   import pnbm_pkg::*;
   logic               valid;
   logic               ready;
   logic [QUERY_W-1:0] pixel_index;
   logic               is_border;
   logic [COUNT_W-1:0] neighbor_count;
   logic               geometry_error;

   modport source (output valid, pixel_index, is_border, neighbor_count, geometry_error,
                   input ready);
   modport sink (input valid, pixel_index, is_border, neighbor_count, geometry_error,
                 output ready);
endinterface

>>> design/pnbm_controller.sv
module pnbm_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic                   req_mode,
   input  logic                   req_last,
   output logic                   req_ready,
   input  pnbm_pkg::status_type   status,
   output pnbm_pkg::op_type       op
);
   import pnbm_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      op        = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = status.rsp_free;
            if (req_valid && status.rsp_free) begin
               if (req_mode) begin
                  op       = OP_QUERY;
                  state_in = ST_CAPTURE;
               end else begin
                  op = OP_LOAD;
                  if (req_last) state_in = ST_BUILD;
               end
            end
         end
         ST_CAPTURE: begin
            op       = OP_CAPTURE;
            state_in = ST_IDLE;
         end
         ST_BUILD: begin
            op       = OP_BUILD;
            state_in = status.skip_build ? ST_IDLE : ST_XI_READ;
         end
         ST_XI_READ: begin
            op       = OP_XI_READ;
            state_in = ST_XI_LATCH;
         end
         ST_XI_LATCH: begin
            op       = OP_XI_LATCH;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            op = OP_SCAN;
            if (status.scan_done) state_in = ST_PREP;
         end
         ST_PREP: begin
            op       = OP_PREP;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            op       = OP_MUL;
            state_in = ST_KEEP;
         end
         ST_KEEP: begin
            op       = OP_KEEP;
            state_in = status.p_last ? ST_NB_DONE : ST_MUL;
         end
         ST_NB_DONE: begin
            op       = OP_NB_DONE;
            state_in = status.i_last ? ST_BM_RD : ST_XI_READ;
         end
         ST_BM_RD: begin
            op       = OP_BM_RD;
            state_in = ST_BM_WR;
         end
         ST_BM_WR: begin
            op = OP_BM_WR;
            priority if (!status.i_last) state_in = ST_BM_RD;
            else if (status.width_one)   state_in = ST_IDLE;
            else                         state_in = ST_GR_RD;
         end
         ST_GR_RD: begin
            op       = OP_GR_RD;
            state_in = ST_GR_LATCH;
         end
         ST_GR_LATCH: begin
            op       = OP_GR_LATCH;
            state_in = ST_GR_TEST;
         end
         ST_GR_TEST: begin
            op = OP_GR_TEST;
            priority if (!status.grow_stop)               state_in = ST_GR_NL;
            else if (status.i_last && status.iter_last)   state_in = ST_IDLE;
            else                                          state_in = ST_GR_RD;
         end
         ST_GR_NL: begin
            op       = OP_GR_NL;
            state_in = ST_GR_NB;
         end
         ST_GR_NB: begin
            op       = OP_GR_NB;
            state_in = ST_GR_TEST;
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> design/pnbm_datapath.sv
module pnbm_datapath #(
   parameter int MAX_PIXELS    = pnbm_pkg::MAX_PIXELS_DEF,
   parameter int MAX_NEIGHBORS = pnbm_pkg::MAX_NEIGHBORS_DEF,
   parameter int COORD_BITS    = pnbm_pkg::COORD_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  pnbm_pkg::op_type                      op,
   output pnbm_pkg::status_type                  status,
   input  logic signed [pnbm_pkg::FIELD_XY_W-1:0] req_pixel_x,
   input  logic signed [pnbm_pkg::FIELD_XY_W-1:0] req_pixel_y,
   input  logic [pnbm_pkg::QUERY_W-1:0]          req_query_index,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [pnbm_pkg::QUERY_W-1:0]          rsp_pixel_index,
   output logic                                  rsp_is_border,
   output logic [pnbm_pkg::COUNT_W-1:0]          rsp_neighbor_count,
   output logic                                  rsp_geometry_error,
   input  logic                                  csr_write_enable,
   input  logic [pnbm_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [pnbm_pkg::CSR_DATA_W-1:0]       csr_data
);
   import pnbm_pkg::*;

   localparam int IW   = $clog2(MAX_PIXELS);
   localparam int CW   = $clog2(MAX_PIXELS + 1);
   localparam int NLD  = MAX_PIXELS * MAX_NEIGHBORS;
   localparam int NLW  = $clog2(NLD);
   localparam int AW   = COORD_BITS + 1;
   localparam int DW   = 2 * COORD_BITS + 3;
   localparam int PW   = DW + NUM_W;
   localparam int CMPW = (CW > QUERY_W) ? CW : QUERY_W;

   // configuration
   logic [1:0] grid_ff;
   logic       diag_ff;
   logic [3:0] width_ff;

   // stores
   logic signed [COORD_BITS-1:0] x_mem [MAX_PIXELS];
   logic signed [COORD_BITS-1:0] y_mem [MAX_PIXELS];
   logic signed [COORD_BITS-1:0] xq_ff, yq_ff;
   logic [IW-1:0]                nl_mem [NLD];
   logic [IW-1:0]                nl_q;
   logic [COUNT_W-1:0]           nt_mem [MAX_PIXELS];
   logic [COUNT_W-1:0]           nt_q;
   logic                         b0_mem [MAX_PIXELS];
   logic                         b1_mem [MAX_PIXELS];
   logic                         b0_q, b1_q;

   // control state
   logic [CW-1:0] pixel_total_ff, built_ff;
   logic          restart_ff, error_ff;
   logic [SLOT_W-1:0] k1_ff;
   logic [NUM_W-1:0]  num_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [3:0]        w_ff, it_ff;
   logic [IW-1:0]     i_ff;
   logic [CW-1:0]     j_ff;
   logic              bank_ff;

   // distance pipeline
   logic signed [COORD_BITS-1:0] xi_ff, yi_ff;
   logic                v1_ff, v2_ff, v3_ff, v4_ff;
   logic [IW-1:0]       j1_ff, j2_ff, j3_ff, j4_ff;
   logic [AW-1:0]       ax_ff, ay_ff;
   logic [2*AW-1:0]     sx_ff, sy_ff;
   logic [DW-1:0]       d4_ff;

   // candidate list
   logic [DW-1:0]     cd_ff [CAND_MAX];
   logic [IW-1:0]     ci_ff [CAND_MAX];
   logic [DW-1:0]     cd_nx [CAND_MAX];
   logic [IW-1:0]     ci_nx [CAND_MAX];
   logic [SLOT_W-1:0] held_ff, held_nx, pos;
   logic              ins_skip;

   // selection
   logic               have_ff;
   logic [PW-1:0]      rhs_ff, prod_ff;
   logic [SLOT_W-1:0]  p_ff;
   logic [COUNT_W-1:0] cnt_ff, maxc_ff;

   // grow
   logic               gb_ff;
   logic [COUNT_W-1:0] gn_ff, gj_ff;

   // query
   logic               q_ok_ff, rsp_valid_ff;
   logic [QUERY_W-1:0] q_idx_ff;
   logic               rsp_border_ff, rsp_error_ff;
   logic [COUNT_W-1:0] rsp_count_ff;

   logic [CW-1:0]     load_idx;
   logic              load_store, issue, self0, have_in, keep, cur_q, i_last;
   logic [DW-1:0]     dsel;
   logic [IW-1:0]     q_addr, xy_addr, nt_addr, bit_addr;
   logic [NLW-1:0]    nl_waddr, nl_raddr;
   logic signed [AW-1:0] dx, dy;

   assign load_idx   = restart_ff ? '0 : pixel_total_ff;
   assign load_store = load_idx < CW'(MAX_PIXELS);
   assign issue      = (op == OP_SCAN) && (j_ff != built_ff);
   assign q_addr     = IW'(req_query_index);
   assign xy_addr    = (op == OP_SCAN) ? j_ff[IW-1:0] : i_ff;
   assign nt_addr    = (op == OP_QUERY) ? q_addr : i_ff;
   assign bit_addr   = (op == OP_QUERY) ? q_addr : ((op == OP_GR_NL) ? nl_q : i_ff);
   assign nl_waddr   = NLW'(i_ff) * NLW'(MAX_NEIGHBORS) + NLW'(cnt_ff);
   assign nl_raddr   = NLW'(i_ff) * NLW'(MAX_NEIGHBORS) + NLW'(gj_ff);
   assign cur_q      = bank_ff ? b1_q : b0_q;
   assign i_last     = (CW'(i_ff) + CW'(1)) == built_ff;
   assign dx         = AW'(xi_ff) - AW'(xq_ff);
   assign dy         = AW'(yi_ff) - AW'(yq_ff);
   assign self0      = ci_ff[0] == i_ff;
   assign dsel       = self0 ? cd_ff[1] : cd_ff[0];
   assign have_in    = self0 ? (held_ff > SLOT_W'(1)) : (held_ff != '0);
   assign keep       = have_ff && (ci_ff[p_ff] != i_ff) && (prod_ff < rhs_ff)
                       && (cnt_ff < COUNT_W'(MAX_NEIGHBORS));

   always_comb begin
      status            = '0;
      status.rsp_free   = !rsp_valid_ff || rsp_ready;
      status.skip_build = (grid_ff == GRID_INVALID) || (pixel_total_ff == '0);
      status.scan_done  = (j_ff == built_ff) && !v1_ff && !v2_ff && !v3_ff && !v4_ff;
      status.p_last     = ((SLOT_W+1)'(p_ff) + (SLOT_W+1)'(1)) == (SLOT_W+1)'(held_ff);
      status.i_last     = i_last;
      status.width_one  = w_ff == 4'd1;
      status.iter_last  = (5'(it_ff) + 5'd1) >= 5'(w_ff);
      status.grow_stop  = gb_ff || (gj_ff == gn_ff);
   end

   // sorted insertion, stable on ties
   always_comb begin
      pos = '0;
      for (int p = 0; p < CAND_MAX; p++) begin
         if ((SLOT_W'(p) < held_ff) && (cd_ff[p] <= d4_ff)) pos = pos + SLOT_W'(1);
      end
      ins_skip = (held_ff == k1_ff) && (pos == k1_ff);
      held_nx  = (held_ff < k1_ff) ? held_ff + SLOT_W'(1) : held_ff;
      for (int p = 0; p < CAND_MAX; p++) begin
         priority if (SLOT_W'(p) < pos) begin
            cd_nx[p] = cd_ff[p];
            ci_nx[p] = ci_ff[p];
         end else if (SLOT_W'(p) == pos) begin
            cd_nx[p] = d4_ff;
            ci_nx[p] = j4_ff;
         end else if (p > 0) begin
            cd_nx[p] = cd_ff[p-1];
            ci_nx[p] = ci_ff[p-1];
         end else begin
            cd_nx[p] = cd_ff[p];
            ci_nx[p] = ci_ff[p];
         end
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (op == OP_LOAD && load_store) begin
         x_mem[load_idx[IW-1:0]] <= COORD_BITS'(req_pixel_x);
         y_mem[load_idx[IW-1:0]] <= COORD_BITS'(req_pixel_y);
      end
      xq_ff <= x_mem[xy_addr];
      yq_ff <= y_mem[xy_addr];
      if (op == OP_KEEP && keep) nl_mem[nl_waddr] <= ci_ff[p_ff];
      nl_q <= nl_mem[nl_raddr];
      if (op == OP_NB_DONE) nt_mem[i_ff] <= cnt_ff;
      nt_q <= nt_mem[nt_addr];
      if (op == OP_BM_WR) b0_mem[i_ff] <= nt_q < maxc_ff;
      if (op == OP_GR_TEST && gb_ff) begin
         if (bank_ff) b0_mem[i_ff] <= gb_ff;
         else         b1_mem[i_ff] <= gb_ff;
      end else if (op == OP_GR_TEST && gj_ff == gn_ff) begin
         if (bank_ff) b0_mem[i_ff] <= gb_ff;
         else         b1_mem[i_ff] <= gb_ff;
      end
      b0_q <= b0_mem[bit_addr];
      b1_q <= b1_mem[bit_addr];
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ff        <= '0;
         diag_ff        <= 1'b0;
         width_ff       <= 4'd1;
         pixel_total_ff <= '0;
         built_ff       <= '0;
         restart_ff     <= 1'b0;
         error_ff       <= 1'b0;
         v1_ff          <= 1'b0;
         v2_ff          <= 1'b0;
         v3_ff          <= 1'b0;
         v4_ff          <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         j_ff           <= '0;
      end else begin
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_GRID_TYPE:    grid_ff  <= csr_data[1:0];
               CSR_DIAGONAL:     diag_ff  <= csr_data[0];
               CSR_BORDER_WIDTH: width_ff <= csr_data[3:0];
               default: ;
            endcase
         end
         if (op == OP_LOAD) begin
            restart_ff     <= 1'b0;
            pixel_total_ff <= load_idx + (load_store ? CW'(1) : CW'(0));
         end
         if (op == OP_BUILD) begin
            built_ff   <= pixel_total_ff;
            error_ff   <= grid_ff == GRID_INVALID;
            restart_ff <= 1'b1;
         end
         if (op == OP_XI_LATCH) j_ff <= '0;
         else if (issue)        j_ff <= j_ff + CW'(1);
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (op == OP_CAPTURE)  rsp_valid_ff <= 1'b1;
         else if (rsp_ready)    rsp_valid_ff <= 1'b0;
      end
   end

   // build datapath
   always_ff @(posedge clock) begin
      if (op == OP_BUILD) begin
         k1_ff   <= K1_HEX;
         num_ff  <= NUM_NEAR;
         den_ff  <= DEN_NEAR;
         if (grid_ff == GRID_SQUARE) begin
            k1_ff <= diag_ff ? K1_DIAG : K1_SQUARE;
            if (diag_ff) begin
               num_ff <= NUM_DIAG;
               den_ff <= DEN_DIAG;
            end
         end
         w_ff    <= (width_ff == '0) ? 4'd1 : width_ff;
         it_ff   <= 4'd1;
         i_ff    <= '0;
         maxc_ff <= '0;
         bank_ff <= 1'b0;
      end
      if (op == OP_XI_LATCH) begin
         xi_ff   <= xq_ff;
         yi_ff   <= yq_ff;
      end
      j1_ff <= j_ff[IW-1:0];
      j2_ff <= j1_ff;
      ax_ff <= dx[AW-1] ? AW'(-dx) : AW'(dx);
      ay_ff <= dy[AW-1] ? AW'(-dy) : AW'(dy);
      j3_ff <= j2_ff;
      sx_ff <= ax_ff * ax_ff;
      sy_ff <= ay_ff * ay_ff;
      j4_ff <= j3_ff;
      d4_ff <= DW'(sx_ff) + DW'(sy_ff);
      if (op == OP_XI_LATCH) begin
         held_ff <= '0;
      end else if (v4_ff && !ins_skip) begin
         held_ff <= held_nx;
         cd_ff   <= cd_nx;
         ci_ff   <= ci_nx;
      end
      if (op == OP_PREP) begin
         rhs_ff  <= PW'(dsel) * PW'(num_ff);
         have_ff <= have_in;
         p_ff    <= '0;
         cnt_ff  <= '0;
      end
      if (op == OP_MUL) prod_ff <= PW'(cd_ff[p_ff]) * PW'(den_ff);
      if (op == OP_KEEP) begin
         p_ff <= p_ff + SLOT_W'(1);
         if (keep) cnt_ff <= cnt_ff + COUNT_W'(1);
      end
      if (op == OP_NB_DONE) begin
         if (cnt_ff > maxc_ff) maxc_ff <= cnt_ff;
         i_ff <= i_last ? '0 : i_ff + IW'(1);
      end
      if (op == OP_BM_WR) i_ff <= i_last ? '0 : i_ff + IW'(1);
      if (op == OP_GR_LATCH) begin
         gb_ff <= cur_q;
         gn_ff <= nt_q;
         gj_ff <= '0;
      end
      if (op == OP_GR_NB) begin
         gb_ff <= gb_ff | cur_q;
         gj_ff <= gj_ff + COUNT_W'(1);
      end
      if (op == OP_GR_TEST && (gb_ff || gj_ff == gn_ff)) begin
         i_ff <= i_last ? '0 : i_ff + IW'(1);
         if (i_last) begin
            bank_ff <= !bank_ff;
            it_ff   <= it_ff + 4'd1;
         end
      end
      if (op == OP_QUERY) begin
         q_idx_ff <= req_query_index;
         q_ok_ff  <= CMPW'(req_query_index) < CMPW'(built_ff);
      end
      if (op == OP_CAPTURE) begin
         rsp_border_ff <= q_ok_ff && !error_ff && cur_q;
         rsp_count_ff  <= (q_ok_ff && !error_ff) ? nt_q : '0;
         rsp_error_ff  <= error_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_index    = q_idx_ff;
   assign rsp_is_border      = rsp_border_ff;
   assign rsp_neighbor_count = rsp_count_ff;
   assign rsp_geometry_error = rsp_error_ff;

endmodule

>>> design/pixel_neighbor_graph_border_mask_unit.sv
// Pixel neighbor graph and border mask. Load transactions (mode 0) store one pixel
// center each while the store has room; the transaction marked last starts the graph
// build, during which no transaction is taken. The build scans one pixel pair per
// cycle through the distance pipeline for each pixel's neighbor list, then passes
// each candidate through the ratio multiplier (multiply state, then keep state),
// then marks the outer ring, then grows each extra border ring with a read, latch
// and test per pixel and a list read and mask read per neighbor visited, set by the
// single read port of the neighbor list and mask memories. Query transactions
// (mode 1) do the registered memory read, then load the result register, and a new
// transaction is taken while a result waits as long as it is taken that cycle.
// Results of a build stay readable until the next build; there is no clearing pass.
module pixel_neighbor_graph_border_mask_unit #(
   parameter int MAX_PIXELS    = pnbm_pkg::MAX_PIXELS_DEF,
   parameter int MAX_NEIGHBORS = pnbm_pkg::MAX_NEIGHBORS_DEF,
   parameter int COORD_BITS    = pnbm_pkg::COORD_BITS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   pnbm_req_if.sink                        req_channel,
   pnbm_rsp_if.source                      rsp_channel,
   input logic                             csr_write_enable,
   input logic [pnbm_pkg::CSR_INDEX_W-1:0] csr_index,
   input logic [pnbm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import pnbm_pkg::*;

   op_type     op;
   status_type status;

   pnbm_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_mode  (req_channel.mode),
      .req_last  (req_channel.last),
      .req_ready (req_channel.ready),
      .status    (status),
      .op        (op)
   );

   pnbm_datapath #(
      .MAX_PIXELS    (MAX_PIXELS),
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .COORD_BITS    (COORD_BITS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .op                 (op),
      .status             (status),
      .req_pixel_x        (req_channel.pixel_x),
      .req_pixel_y        (req_channel.pixel_y),
      .req_query_index    (req_channel.query_index),
      .rsp_ready          (rsp_channel.ready),
      .rsp_valid          (rsp_channel.valid),
      .rsp_pixel_index    (rsp_channel.pixel_index),
      .rsp_is_border      (rsp_channel.is_border),
      .rsp_neighbor_count (rsp_channel.neighbor_count),
      .rsp_geometry_error (rsp_channel.geometry_error),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   a_query_result: assert property (@(posedge clock) disable iff (reset)
      req_channel.valid && req_channel.ready && req_channel.mode |=> ##1 rsp_channel.valid)
      else $error("query transaction produced no result");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_channel.valid) |-> $past(op == OP_CAPTURE))
      else $error("result raised without capture");

   a_busy_build: assert property (@(posedge clock) disable iff (reset)
      (op == OP_SCAN || op == OP_GR_TEST) |-> !req_channel.ready)
      else $error("transaction taken during build");

endmodule
